@@ sv/wpsd_pkg.sv @@
// wpsd_pkg: shared constants, types and codes for the wrapped point sum dedup block
// no dependencies; every other file of the block refers to it by scoped names

package wpsd_pkg;

    // store geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // fixed point format of the coordinates
    localparam int FRAC_BITS = 24;
    localparam int IN_W      = 32;

    // result field widths, fixed by the stream format
    localparam int COORD_W = 24;
    localparam int ENTRY_W = 8;
    localparam int COUNT_W = 9;

    // tolerance register
    localparam int           TOL_W     = 32;
    localparam logic [31:0]  TOL_RESET = 32'd281;

    // distance arithmetic
    localparam int SQ_W   = 2 * FRAC_BITS;
    localparam int DIST_W = SQ_W + 2;
    localparam int CMP_W  = (DIST_W > TOL_W) ? DIST_W : TOL_W;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // stream widths and field offsets
    localparam int IN_TDATA_W   = 6 * IN_W;
    localparam int OUT_FIELDS_W = 3 * COORD_W + 1 + ENTRY_W + 1 + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int OFS_IS_NEW   = 3 * COORD_W;
    localparam int OFS_ENTRY    = OFS_IS_NEW + 1;
    localparam int OFS_FULL     = OFS_ENTRY + ENTRY_W;
    localparam int OFS_COUNT    = OFS_FULL + 1;

    // one wrapped point
    typedef struct packed {
        logic [FRAC_BITS-1:0] z;
        logic [FRAC_BITS-1:0] y;
        logic [FRAC_BITS-1:0] x;
    } point_t;

    // head of the queue as seen by the back part
    typedef struct packed {
        logic   valid;
        point_t point;
    } queue_out_t;

    // one result item
    typedef struct packed {
        logic [COUNT_W-1:0] unique_count;
        logic               table_full;
        logic [ENTRY_W-1:0] entry_index;
        logic               is_new;
        logic [COORD_W-1:0] sum_z;
        logic [COORD_W-1:0] sum_y;
        logic [COORD_W-1:0] sum_x;
    } result_t;

    // back part sequencer
    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DONE
    } back_state_t;

endpackage

@@ sv/wpsd_front.sv @@
// wpsd_front: accepts input requests, forms the wrapped sum and hands it to the queue
// depends on wpsd_pkg

module wpsd_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [wpsd_pkg::IN_TDATA_W-1:0]   in_data,
    output logic                              push_valid,
    input  logic                              push_ready,
    output wpsd_pkg::point_t                  push_point
);

    logic             hold_valid_reg;
    logic             hold_valid_next;
    wpsd_pkg::point_t hold_point_reg;
    wpsd_pkg::point_t sum_point;
    logic             in_fire;

    // wrap by keeping only the fraction bits of each coordinate sum
    always_comb
    begin
        sum_point.x = in_data[0 * wpsd_pkg::IN_W +: wpsd_pkg::FRAC_BITS]
                    + in_data[3 * wpsd_pkg::IN_W +: wpsd_pkg::FRAC_BITS];
        sum_point.y = in_data[1 * wpsd_pkg::IN_W +: wpsd_pkg::FRAC_BITS]
                    + in_data[4 * wpsd_pkg::IN_W +: wpsd_pkg::FRAC_BITS];
        sum_point.z = in_data[2 * wpsd_pkg::IN_W +: wpsd_pkg::FRAC_BITS]
                    + in_data[5 * wpsd_pkg::IN_W +: wpsd_pkg::FRAC_BITS];
    end

    // holding stage ahead of the queue
    assign in_ready   = !hold_valid_reg || push_ready;
    assign in_fire    = in_valid && in_ready;
    assign push_valid = hold_valid_reg;
    assign push_point = hold_point_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_fire)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hold_point_reg <= sum_point;
        end
    end

endmodule

@@ sv/wpsd_queue.sv @@
// wpsd_queue: short queue of wrapped points between the front and back parts
// depends on wpsd_pkg

module wpsd_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  wpsd_pkg::point_t       push_point,
    output wpsd_pkg::queue_out_t   head,
    input  logic                   pop
);

    wpsd_pkg::point_t                entry_reg [wpsd_pkg::QUEUE_DEPTH];
    logic [wpsd_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [wpsd_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [wpsd_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [wpsd_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [wpsd_pkg::QCNT_W-1:0]     fill_reg;
    logic [wpsd_pkg::QCNT_W-1:0]     fill_next;
    logic                            push;
    logic                            do_pop;

    assign push_ready = (fill_reg != wpsd_pkg::QCNT_W'(wpsd_pkg::QUEUE_DEPTH));
    assign push       = push_valid && push_ready;
    assign do_pop     = pop && (fill_reg != '0);

    assign head.valid = (fill_reg != '0);
    assign head.point = entry_reg[rd_ptr_reg];

    // pointer and fill update with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == wpsd_pkg::QPTR_W'(wpsd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == wpsd_pkg::QPTR_W'(wpsd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_point;
        end
    end

endmodule

@@ sv/wpsd_back.sv @@
// wpsd_back: scans the unique point store, decides match or append, drives the result
// depends on wpsd_pkg; holds the point memory and the tolerance register

module wpsd_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [wpsd_pkg::TOL_W-1:0]    cfg_wr_data,
    input  wpsd_pkg::queue_out_t          head,
    output logic                          pop,
    output logic                          res_valid,
    input  logic                          res_ready,
    output wpsd_pkg::result_t             res
);

    // point memory
    wpsd_pkg::point_t                   mem [wpsd_pkg::TABLE_DEPTH];
    wpsd_pkg::point_t                   mem_rd_reg;
    logic                               mem_rd_en;
    logic                               mem_wr_en;
    logic [wpsd_pkg::IDX_W-1:0]         rd_addr;
    logic [wpsd_pkg::IDX_W-1:0]         wr_addr;

    // control state
    wpsd_pkg::back_state_t              state_reg;
    wpsd_pkg::back_state_t              state_next;
    logic [wpsd_pkg::TOL_W-1:0]         tol_reg;
    logic [wpsd_pkg::CNT_W-1:0]         count_reg;
    logic [wpsd_pkg::CNT_W-1:0]         count_next;
    logic [wpsd_pkg::CNT_W-1:0]         issue_reg;
    logic [wpsd_pkg::CNT_W-1:0]         issue_next;
    logic                               v1_reg;
    logic                               v1_next;
    logic                               v2_reg;
    logic                               v2_next;
    logic                               found_reg;
    logic                               found_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;

    // payload state
    wpsd_pkg::point_t                   pt_reg;
    wpsd_pkg::point_t                   pt_next;
    logic [wpsd_pkg::IDX_W-1:0]         idx1_reg;
    logic [wpsd_pkg::IDX_W-1:0]         idx1_next;
    logic [wpsd_pkg::IDX_W-1:0]         idx2_reg;
    logic [wpsd_pkg::IDX_W-1:0]         idx2_next;
    logic [wpsd_pkg::IDX_W-1:0]         match_reg;
    logic [wpsd_pkg::IDX_W-1:0]         match_next;
    logic [wpsd_pkg::SQ_W-1:0]          sq_reg   [3];
    logic [wpsd_pkg::SQ_W-1:0]          sq_next  [3];
    wpsd_pkg::result_t                  res_reg;
    wpsd_pkg::result_t                  res_next;

    // datapath wires
    logic [wpsd_pkg::FRAC_BITS-1:0]     coord_a  [3];
    logic [wpsd_pkg::FRAC_BITS-1:0]     coord_b  [3];
    logic [wpsd_pkg::FRAC_BITS-1:0]     diff     [3];
    logic [wpsd_pkg::DIST_W-1:0]        dist_sum;
    logic                               in_tol;
    logic                               room;
    logic                               append;

    assign rd_addr   = issue_reg[wpsd_pkg::IDX_W-1:0];
    assign wr_addr   = count_reg[wpsd_pkg::IDX_W-1:0];
    assign res_valid = out_valid_reg;
    assign res       = res_reg;
    assign room      = (count_reg != wpsd_pkg::CNT_W'(wpsd_pkg::TABLE_DEPTH));
    assign append    = !found_reg && room;

    // absolute coordinate differences against the stored entry
    always_comb
    begin
        coord_a[0] = pt_reg.x;
        coord_a[1] = pt_reg.y;
        coord_a[2] = pt_reg.z;
        coord_b[0] = mem_rd_reg.x;
        coord_b[1] = mem_rd_reg.y;
        coord_b[2] = mem_rd_reg.z;
        for (int k = 0; k < 3; k++)
        begin
            diff[k]    = (coord_a[k] >= coord_b[k]) ? coord_a[k] - coord_b[k]
                                                    : coord_b[k] - coord_a[k];
            sq_next[k] = wpsd_pkg::SQ_W'(diff[k]) * wpsd_pkg::SQ_W'(diff[k]);
        end
    end

    // squared distance and tolerance test
    assign dist_sum = wpsd_pkg::DIST_W'(sq_reg[0]) + wpsd_pkg::DIST_W'(sq_reg[1])
                    + wpsd_pkg::DIST_W'(sq_reg[2]);
    assign in_tol   = (wpsd_pkg::CMP_W'(dist_sum) <= wpsd_pkg::CMP_W'(tol_reg));

    // sequencer: pop, scan the store one entry a cycle, then settle the result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        found_next     = found_reg;
        match_next     = match_reg;
        pt_next        = pt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        idx1_next      = idx1_reg;
        v1_next        = 1'b0;
        v2_next        = v1_reg;
        idx2_next      = idx1_reg;
        mem_rd_en      = 1'b0;
        mem_wr_en      = 1'b0;
        pop            = 1'b0;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        // first match in scan order is the lowest index
        if (v2_reg && !found_reg && in_tol)
        begin
            found_next = 1'b1;
            match_next = idx2_reg;
        end

        case (state_reg)
            wpsd_pkg::B_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    pt_next    = head.point;
                    issue_next = '0;
                    found_next = 1'b0;
                    match_next = '0;
                    state_next = wpsd_pkg::B_SCAN;
                end
            end
            wpsd_pkg::B_SCAN:
            begin
                if (!found_reg && (issue_reg < count_reg))
                begin
                    mem_rd_en  = 1'b1;
                    v1_next    = 1'b1;
                    idx1_next  = rd_addr;
                    issue_next = issue_reg + 1'b1;
                end
                if ((found_reg || (issue_reg == count_reg)) && !v1_reg && !v2_reg)
                begin
                    state_next = wpsd_pkg::B_DONE;
                end
            end
            wpsd_pkg::B_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    res_next.sum_x      = wpsd_pkg::COORD_W'(pt_reg.x);
                    res_next.sum_y      = wpsd_pkg::COORD_W'(pt_reg.y);
                    res_next.sum_z      = wpsd_pkg::COORD_W'(pt_reg.z);
                    res_next.is_new     = !found_reg;
                    res_next.table_full = !found_reg && !room;
                    if (found_reg)
                    begin
                        res_next.entry_index = wpsd_pkg::ENTRY_W'(match_reg);
                    end
                    else if (room)
                    begin
                        res_next.entry_index = wpsd_pkg::ENTRY_W'(wr_addr);
                    end
                    else
                    begin
                        res_next.entry_index = '0;
                    end
                    if (append)
                    begin
                        mem_wr_en  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    res_next.unique_count = wpsd_pkg::COUNT_W'(count_next);
                    out_valid_next        = 1'b1;
                    state_next            = wpsd_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = wpsd_pkg::B_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wpsd_pkg::B_IDLE;
            tol_reg       <= wpsd_pkg::TOL_RESET;
            count_reg     <= '0;
            issue_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                tol_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pt_reg    <= pt_next;
        idx1_reg  <= idx1_next;
        idx2_reg  <= idx2_next;
        match_reg <= match_next;
        res_reg   <= res_next;
        for (int k = 0; k < 3; k++)
        begin
            sq_reg[k] <= sq_next[k];
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            mem_rd_reg <= mem[rd_addr];
        end
        if (mem_wr_en)
        begin
            mem[wr_addr] <= pt_reg;
        end
    end

endmodule

@@ sv/wrapped_point_sum_dedup.sv @@
// wrapped_point_sum_dedup: top level of the wrapped point sum and dedup block
// depends on wpsd_pkg, wpsd_front, wpsd_queue and wpsd_back
//
// Usage:
//   s_axis carries one request per item: two 3D points in signed fixed point
//   with 24 fraction bits. Each request yields exactly one m_axis result: the
//   sum wrapped into [0,1), whether it was new, its entry index, the full flag
//   and the number of stored unique points after the item.
//   cfg_wr_en/cfg_wr_data write the squared tolerance; write it only while
//   the block is idle.
//   The store holds at most 256 unique points. It is a single memory read
//   one entry a cycle, and a match ends the scan early. The front stage and a
//   two-entry queue keep taking requests while the back part works.
//   Reset empties the store, clears all queues and sets the tolerance to 281.
//   When the receiver stalls, the result is held in the output register, the
//   next item is still scanned, and input requests are refused once the
//   front stage and queue fill up.

module wrapped_point_sum_dedup
(
    input  logic                                clk,
    input  logic                                rst_n,
    // base_x, base_y, base_z, shift_x, shift_y, shift_z (32 bits each)
    input  logic [wpsd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sum_x, sum_y, sum_z (24 each), is_new, entry_index (8), table_full,
    // unique_count (9), zero fill
    output logic [wpsd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_wr_en,
    input  logic [wpsd_pkg::TOL_W-1:0]          cfg_wr_data
);

    logic                   push_valid;
    logic                   push_ready;
    wpsd_pkg::point_t       push_point;
    wpsd_pkg::queue_out_t   head;
    logic                   pop;
    wpsd_pkg::result_t      res;

    // front: accept and wrap
    wpsd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_point (push_point)
    );

    // queue between the parts
    wpsd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_point (push_point),
        .head       (head),
        .pop        (pop)
    );

    // back: scan, match or append, result register
    wpsd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .pop         (pop),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    // result packing, first field in the lowest bits
    assign m_axis_tdata = {{wpsd_pkg::OUT_PAD_W{1'b0}}, res};

endmodule

@@ sv/wpsd_checker.sv @@
// wpsd_checker: port-level assertions for wrapped_point_sum_dedup, bound to the top
// depends on wpsd_pkg

module wpsd_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [wpsd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready
);

    logic                           out_fire;
    logic                           is_new;
    logic                           full;
    logic [wpsd_pkg::ENTRY_W-1:0]   entry;
    logic [wpsd_pkg::COUNT_W-1:0]   cnt;
    logic [wpsd_pkg::COUNT_W-1:0]   last_cnt_reg;
    logic [wpsd_pkg::COUNT_W-1:0]   last_plus;
    logic [wpsd_pkg::COUNT_W-1:0]   cnt_minus;

    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign is_new    = m_axis_tdata[wpsd_pkg::OFS_IS_NEW];
    assign full      = m_axis_tdata[wpsd_pkg::OFS_FULL];
    assign entry     = m_axis_tdata[wpsd_pkg::OFS_ENTRY +: wpsd_pkg::ENTRY_W];
    assign cnt       = m_axis_tdata[wpsd_pkg::OFS_COUNT +: wpsd_pkg::COUNT_W];
    assign last_plus = last_cnt_reg + 1'b1;
    assign cnt_minus = cnt - 1'b1;

    // store size seen at the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cnt_reg <= '0;
        end
        else if (out_fire)
        begin
            last_cnt_reg <= cnt;
        end
    end

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // an append grows the store by one and lands in the last slot
    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && is_new && !full |->
            (cnt == last_plus) && (entry == wpsd_pkg::ENTRY_W'(cnt_minus)))
        else $error("append did not land in the next slot");

    // a match leaves the store alone and points inside it
    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !is_new |->
            !full && (cnt == last_cnt_reg) && (wpsd_pkg::COUNT_W'(entry) < cnt))
        else $error("match result inconsistent with the store");

    // full only on a new point with the store at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && full |->
            is_new && (entry == '0) && (cnt == last_cnt_reg)
            && (cnt == wpsd_pkg::COUNT_W'(wpsd_pkg::TABLE_DEPTH)))
        else $error("full flag with room left");

endmodule

bind wrapped_point_sum_dedup wpsd_checker u_wpsd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
